[hdl/full_transition_logsumexp_forward_macros.svh]
// Assertion macros for the log-sum-exp forward block.
`ifndef FULL_TRANSITION_LOGSUMEXP_FORWARD_MACROS_SVH
`define FULL_TRANSITION_LOGSUMEXP_FORWARD_MACROS_SVH
`ifndef SYNTHESIS
`define FTLF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FTLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FTLF_ASSERT(label, clk, rst_n, prop, msg)
`define FTLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[hdl/ftlf_pkg.sv]
// Package with types, constants and the log-add helpers of the forward block.
package ftlf_pkg;
	localparam int MaxStates = 32;
	localparam int FracBits = 16;
	localparam int StW = $clog2(MaxStates);
	localparam int CntW = StW + 1;
	localparam int TabAw = 2 * StW;
	localparam int PathAw = StW + 1;
	localparam int CorrEntries = 48;

	localparam logic CMD_TRANS = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	typedef struct packed {
		logic command;
		logic [4:0] to_state;
		logic [4:0] from_state;
		logic signed [31:0] score;
		logic last_frame;
	} req_t;

	typedef struct packed {
		logic signed [31:0] total_score;
		logic saturated;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ACC, ST_STORE, ST_TOT, ST_OUT
	} fsm_t;

	typedef struct packed {
		logic rd_en;
		logic [TabAw-1:0] tab_addr;
		logic [PathAw-1:0] path_addr;
		logic first;
		logic last;
	} rd_ctl_t;

	function automatic logic [31:0] corr_q16(input logic [5:0] k);
		logic [31:0] c;
		unique case (k)
			6'd0: c = 45426; 6'd1: c = 37745; 6'd2: c = 31069; 6'd3: c = 25354;
			6'd4: c = 20530; 6'd5: c = 16510; 6'd6: c = 13200; 6'd7: c = 10500;
			6'd8: c = 8318; 6'd9: c = 6567; 6'd10: c = 5170; 6'd11: c = 4061;
			6'd12: c = 3184; 6'd13: c = 2493; 6'd14: c = 1950; 6'd15: c = 1523;
			6'd16: c = 1189; 6'd17: c = 928; 6'd18: c = 724; 6'd19: c = 565;
			6'd20: c = 440; 6'd21: c = 343; 6'd22: c = 267; 6'd23: c = 208;
			6'd24: c = 162; 6'd25: c = 126; 6'd26: c = 98; 6'd27: c = 77;
			6'd28: c = 60; 6'd29: c = 47; 6'd30: c = 36; 6'd31: c = 28;
			6'd32: c = 22; 6'd33: c = 17; 6'd34: c = 13; 6'd35: c = 10;
			6'd36: c = 8; 6'd37: c = 6; 6'd38: c = 5; 6'd39: c = 4;
			6'd40: c = 3; 6'd41: c = 2; 6'd42: c = 2; 6'd43: c = 1;
			6'd44: c = 1; 6'd45: c = 1; 6'd46: c = 1; 6'd47: c = 1;
			default: c = 0;
		endcase
		return c;
	endfunction

	function automatic logic signed [39:0] log_add(input logic signed [39:0] a,
			input logic signed [39:0] b);
		logic signed [39:0] m;
		logic [39:0] d;
		logic [39:0] k;
		logic [31:0] c;
		m = (a > b) ? a : b;
		d = (a > b) ? 40'(a - b) : 40'(b - a);
		k = (d + (40'd1 << (FracBits - 3))) >> (FracBits - 2);
		c = (k >= 40'(CorrEntries)) ? 32'd0 : corr_q16(k[5:0]);
		if (FracBits < 16)
			c = (c + (32'd1 << (16 - FracBits - 1))) >> (16 - FracBits);
		else
			c = c << (FracBits - 16);
		return m + 40'(signed'({1'b0, c}));
	endfunction
endpackage

[hdl/ftlf_mem.sv]
// Transition table and two-bank path score memories with registered reads.
module ftlf_mem
	import ftlf_pkg::*;
(
	input logic clk,
	input logic tab_we,
	input logic [TabAw-1:0] tab_waddr,
	input logic [31:0] tab_wdata,
	input logic [TabAw-1:0] tab_raddr,
	output logic [31:0] tab_rdata,
	input logic path_we,
	input logic [PathAw-1:0] path_waddr,
	input logic [31:0] path_wdata,
	input logic [PathAw-1:0] path_raddr,
	output logic [31:0] path_rdata
);
	logic [31:0] tab_mem [MaxStates*MaxStates];
	logic [31:0] path_mem [2*MaxStates];

	always_ff @(posedge clk) begin
		if (tab_we)
			tab_mem[tab_waddr] <= tab_wdata;
		tab_rdata <= tab_mem[tab_raddr];
	end

	always_ff @(posedge clk) begin
		if (path_we)
			path_mem[path_waddr] <= path_wdata;
		path_rdata <= path_mem[path_raddr];
	end
endmodule

[hdl/ftlf_acc.sv]
// Accumulator that folds log-add over memory reads, one term a cycle.
module ftlf_acc
	import ftlf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input rd_ctl_t ctl,
	input logic use_tab,
	input logic [31:0] tab_rdata,
	input logic [31:0] path_rdata,
	output logic signed [39:0] acc,
	output logic done
);
	rd_ctl_t ctl_s1;
	logic use_tab_s1;
	logic signed [39:0] z;
	logic signed [39:0] acc_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			use_tab_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			use_tab_s1 <= use_tab;
			done_q <= ctl_s1.rd_en && ctl_s1.last;
		end
	end

	always_comb begin
		z = 40'(signed'(path_rdata));
		if (use_tab_s1)
			z = z + 40'(signed'(tab_rdata));
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.rd_en)
			acc_q <= ctl_s1.first ? z : log_add(acc_q, z);
	end

	assign acc = acc_q;
	assign done = done_q;
endmodule

[hdl/full_transition_logsumexp_forward.sv]
// Top level of the log-domain forward recursion block.
// Usage: transition scores are written first with command 0, one request each.
// Emission scores then follow with command 1, one per state in state order,
// frame after frame. The configuration register n_states sets the states in
// use; the user must see that it is written over the APB port only while
// idle, as the block itself does not enforce it. An emission in the first
// frame is stored directly from idle; in later frames it is folded over one
// read of the transition and path memories per previous state, and the block
// takes no new request until it is stored. Completing the last frame adds a
// total pass, after which one result appears on the output. The output
// register holds the result while the receiver stalls; the block takes no new
// input request until the result is taken. Reset clears the control state and
// sets n_states to 32; the memories are not cleared and need no clearing pass.
module full_transition_logsumexp_forward
	import ftlf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output rsp_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	`include "full_transition_logsumexp_forward_macros.svh"

	fsm_t state_q, state_d;
	logic [5:0] nreg_q;
	logic [CntW-1:0] n_eff;
	logic bank_q, first_q, sat_q;
	logic [CntW-1:0] cnt_q;
	logic [CntW-1:0] j_q, j_d;
	req_t req_q;
	rsp_t out_q;
	logic out_valid_q;
	logic accept;
	logic sat_set;

	rd_ctl_t ctl;
	logic use_tab;
	logic signed [39:0] acc;
	logic acc_done;
	logic [31:0] tab_rdata, path_rdata;
	logic tab_we, path_we;
	logic [31:0] path_wdata;
	logic signed [39:0] sum;
	logic [31:0] sat_val;
	logic sat_hit;
	logic [StW-1:0] idx;

	assign pready = 1'b1;
	assign prdata = {26'd0, nreg_q};

	always_comb begin
		if (nreg_q == 6'd0)
			n_eff = CntW'(1);
		else if (nreg_q > 6'(MaxStates))
			n_eff = CntW'(MaxStates);
		else
			n_eff = CntW'(nreg_q);
	end

	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign idx = cnt_q[StW-1:0];

	always_comb begin
		if (state_q == ST_STORE)
			sum = acc + 40'(req_q.score);
		else if (state_q == ST_IDLE)
			sum = 40'(in_data.score);
		else
			sum = acc;
		sat_hit = 1'b0;
		if (sum > 40'sd2147483647) begin
			sat_val = 32'h7fffffff;
			sat_hit = 1'b1;
		end else if (sum < -40'sd2147483648) begin
			sat_val = 32'h80000000;
			sat_hit = 1'b1;
		end else begin
			sat_val = sum[31:0];
		end
	end

	always_comb begin
		state_d = state_q;
		j_d = j_q;
		ctl = '0;
		use_tab = 1'b0;
		tab_we = 1'b0;
		path_we = 1'b0;
		path_wdata = sat_val;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_data.command == CMD_TRANS) begin
					tab_we = 1'b1;
				end else if (accept && first_q) begin
					path_we = 1'b1;
					if (cnt_q + CntW'(1) >= n_eff && in_data.last_frame)
						state_d = ST_TOT;
					j_d = '0;
				end else if (accept) begin
					state_d = ST_ACC;
					j_d = '0;
				end
			end
			ST_ACC: begin
				use_tab = 1'b1;
				if (j_q < n_eff) begin
					ctl.rd_en = 1'b1;
					ctl.first = (j_q == '0);
					ctl.last = (j_q + CntW'(1) == n_eff);
					j_d = j_q + CntW'(1);
				end
				if (acc_done)
					state_d = ST_STORE;
			end
			ST_STORE: begin
				path_we = 1'b1;
				j_d = '0;
				state_d = (cnt_q + CntW'(1) >= n_eff && req_q.last_frame) ? ST_TOT : ST_IDLE;
			end
			ST_TOT: begin
				if (j_q < n_eff) begin
					ctl.rd_en = 1'b1;
					ctl.first = (j_q == '0);
					ctl.last = (j_q + CntW'(1) == n_eff);
					j_d = j_q + CntW'(1);
				end
				if (acc_done)
					state_d = ST_OUT;
			end
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		ctl.tab_addr = {idx, j_q[StW-1:0]};
		ctl.path_addr = (state_q == ST_TOT) ? {bank_q, j_q[StW-1:0]} : {bank_q, j_q[StW-1:0]};
	end

	assign sat_set = (path_we || state_q == ST_OUT) && sat_hit;

	ftlf_mem u_mem (
		.clk(clk),
		.tab_we(tab_we),
		.tab_waddr({in_data.to_state[StW-1:0], in_data.from_state[StW-1:0]}),
		.tab_wdata(in_data.score),
		.tab_raddr(ctl.tab_addr),
		.tab_rdata(tab_rdata),
		.path_we(path_we),
		.path_waddr({~bank_q, idx}),
		.path_wdata(path_wdata),
		.path_raddr(ctl.path_addr),
		.path_rdata(path_rdata)
	);

	ftlf_acc u_acc (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.use_tab(use_tab),
		.tab_rdata(tab_rdata),
		.path_rdata(path_rdata),
		.acc(acc),
		.done(acc_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nreg_q <= 6'd32;
			bank_q <= 1'b0;
			first_q <= 1'b1;
			sat_q <= 1'b0;
			cnt_q <= '0;
			j_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			j_q <= j_d;
			if (psel && penable && pwrite && paddr == 2'd0)
				nreg_q <= pwdata[5:0];
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (sat_set && state_q != ST_OUT)
				sat_q <= 1'b1;
			if (path_we) begin
				if (cnt_q + CntW'(1) >= n_eff) begin
					cnt_q <= '0;
					bank_q <= ~bank_q;
					first_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CntW'(1);
				end
			end
			if (state_q == ST_OUT) begin
				out_q.total_score <= sat_val;
				out_q.saturated <= sat_q || sat_hit;
				out_valid_q <= 1'b1;
				first_q <= 1'b1;
				sat_q <= 1'b0;
				bank_q <= 1'b0;
			end
		end
	end

	`FTLF_ASSERT(a_cnt_range, clk, arst_n, cnt_q < CntW'(MaxStates), "emission count out of range")
	`FTLF_ASSERT(a_no_accept_busy, clk, arst_n, !(accept && state_q != ST_IDLE), "accept while busy")
	`FTLF_ASSERT_NEXT(a_out_after, clk, arst_n, state_q == ST_OUT, out_valid_q && first_q, "result not posted")
endmodule
